[design/tosp_pkg.sv]
package tosp_pkg;

	// Field widths
	localparam int DATA_W     = 32;
	localparam int SAMPLE_W   = 24;
	localparam int PROD_W     = 64;
	localparam int FRAC_SHIFT = 12;
	localparam int STEP_W     = PROD_W - FRAC_SHIFT;

	// Reciprocal sample rate after reset (48 kHz)
	localparam logic [DATA_W-1:0] ISR_RESET = 32'd89478;

	// Phase step bounds: plus or minus half a cycle
	localparam logic signed [STEP_W-1:0] STEP_MAX   = 52'sd2147483648;
	localparam logic signed [STEP_W-1:0] STEP_MIN   = -STEP_MAX;
	localparam logic        [DATA_W-1:0] HALF_CYCLE = 32'h8000_0000;

	// Sync value of exactly 1.0 in Q8.24
	localparam logic signed [DATA_W-1:0] SYNC_ONE = 32'sd16777216;

	// Full-scale sample (1.0 with 22 fractional bits)
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE = 24'sd4194304;

	// Stage one contents handed from the front end to the phase core
	typedef struct packed {
		logic                     vld;
		logic signed [STEP_W-1:0] step_raw;
		logic [DATA_W-1:0]        delta;
		logic                     sync_hit;
		logic [DATA_W-1:0]        sync_phase;
	} tosp_s1_t;

endpackage

[design/tosp_in_if.sv]
interface tosp_in_if;
	import tosp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] freq_hz;
	logic        [DATA_W-1:0] pm_offset;
	logic signed [DATA_W-1:0] sync_value;

	modport source (output valid, output freq_hz, output pm_offset, output sync_value,
		input ready);
	modport sink (input valid, input freq_hz, input pm_offset, input sync_value,
		output ready);
endinterface

[design/tosp_out_if.sv]
interface tosp_out_if;
	import tosp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] wave_sample;

	modport source (output valid, output wave_sample, input ready);
	modport sink (input valid, input wave_sample, output ready);
endinterface

[design/tosp_cfg_if.sv]
interface tosp_cfg_if;
	import tosp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] inv_sample_rate;

	modport source (output valid, output inv_sample_rate, input ready);
	modport sink (input valid, input inv_sample_rate, output ready);
endinterface

[design/triangle_oscillator_sync_pm_unit.sv]
// Triangle oscillator with phase sync and phase modulation.
// sample_in carries one item per sample: freq_hz (signed Q20.12),
// pm_offset (unsigned Q0.32) and sync_value (signed Q8.24). sample_out
// returns one wave_sample per item, signed with 22 fractional bits, in order.
// cfg writes inv_sample_rate (unsigned Q0.32); it is always ready and should
// be written only while no sample is in flight.
// An accepted item is registered in stage one and then in the output register;
// a stall at the output can hold it in stage one between the two.
// Throughput is one item per cycle while the receiver does not stall,
// set by the single phase accumulator update in the output stage.
// When the receiver stalls, the output register holds its sample and the
// stage-one register still takes one more item; after that sample_in.ready
// drops until the output is taken.
// Reset (arst_n low) clears the phase, the previous offset and both valid
// flags, and loads inv_sample_rate with 89478 (48 kHz).
module triangle_oscillator_sync_pm_unit (
	input  logic       clk,
	input  logic       arst_n,
	tosp_in_if.sink    sample_in,
	tosp_out_if.source sample_out,
	tosp_cfg_if.sink   cfg
);
	import tosp_pkg::*;

	logic [DATA_W-1:0] isr_q;
	logic              adv;
	tosp_s1_t          s1;

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isr_q <= ISR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			isr_q <= cfg.inv_sample_rate;
		end
	end

	tosp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_in       (sample_in),
		.inv_sample_rate (isr_q),
		.adv             (adv),
		.s1              (s1)
	);

	tosp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (s1),
		.sample_out (sample_out),
		.adv        (adv)
	);

`ifndef ASSERT_OFF
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in.valid && sample_in.ready |=> s1.vld)
		else $error("accepted item did not reach stage one");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1.vld && sample_out.valid && !sample_out.ready |-> !sample_in.ready)
		else $error("input taken while both stages are full and stalled");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1.vld && (!sample_out.valid || sample_out.ready) |=> sample_out.valid)
		else $error("stage one item lost on its way to the output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid |-> ($signed(sample_out.wave_sample) <= SAMPLE_ONE &&
			$signed(sample_out.wave_sample) >= -SAMPLE_ONE))
		else $error("triangle sample out of range");
`endif

endmodule

[design/tosp_front.sv]
module tosp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	tosp_in_if.sink                   sample_in,
	input  logic [tosp_pkg::DATA_W-1:0] inv_sample_rate,
	input  logic                      adv,
	output tosp_pkg::tosp_s1_t        s1
);
	import tosp_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic        [DATA_W-1:0] prev_offset_q;
	logic                     take;
	tosp_s1_t                 stage_s1;

	// Stage one may refill when empty or when the core drains it
	assign sample_in.ready = !stage_s1.vld || adv;
	assign take            = sample_in.valid && sample_in.ready;

	// Frequency times reciprocal sample rate, Q20.44
	assign prod = PROD_W'(sample_in.freq_hz) * PROD_W'($signed({1'b0, inv_sample_rate}));

	// Register the floored step, offset change and sync decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1      <= '0;
			prev_offset_q <= '0;
		end else if (sample_in.ready) begin
			stage_s1.vld <= sample_in.valid;
			if (take) begin
				stage_s1.step_raw   <= prod[PROD_W-1:FRAC_SHIFT];
				stage_s1.delta      <= sample_in.pm_offset - prev_offset_q;
				stage_s1.sync_hit   <= (sample_in.sync_value > 0) &&
					(sample_in.sync_value <= SYNC_ONE);
				stage_s1.sync_phase <= {sample_in.sync_value[DATA_W-9:0], 8'h00};
				prev_offset_q       <= sample_in.pm_offset;
			end
		end
	end

	assign s1 = stage_s1;

endmodule

[design/tosp_core.sv]
module tosp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  tosp_pkg::tosp_s1_t s1,
	tosp_out_if.source         sample_out,
	output logic               adv
);
	import tosp_pkg::*;

	logic [DATA_W-1:0]   phase_q;
	logic [DATA_W-1:0]   mid;
	logic [DATA_W-1:0]   step;
	logic [SAMPLE_W-1:0] sample_q;
	logic                vld_q;
	logic                clip;

	// Fold the top 24 phase bits into a triangle
	function automatic logic [SAMPLE_W-1:0] fold(input logic [DATA_W-1:0] phase);
		logic [SAMPLE_W-1:0] t;
		t = phase[DATA_W-1:DATA_W-SAMPLE_W];
		if (t[SAMPLE_W-1] ^ t[SAMPLE_W-2])
			return {1'b1, {(SAMPLE_W-1){1'b0}}} - t;
		return t;
	endfunction

	// Clip the step to half a cycle either way
	assign clip = (s1.step_raw > STEP_MAX) || (s1.step_raw < STEP_MIN);
	assign step = clip ? HALF_CYCLE : s1.step_raw[DATA_W-1:0];

	// Phase seen by this sample: sync load or offset modulation
	assign mid = s1.sync_hit ? s1.sync_phase : phase_q + s1.delta;

	// Output register frees up when empty or taken
	assign adv = !vld_q || sample_out.ready;

	// Advance phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= '0;
		end else if (adv) begin
			vld_q <= s1.vld;
			if (s1.vld)
				phase_q <= mid + step;
		end
	end

	// Hold the sample until it is taken
	always_ff @(posedge clk) begin
		if (adv && s1.vld)
			sample_q <= fold(mid);
	end

	assign sample_out.valid       = vld_q;
	assign sample_out.wave_sample = sample_q;

endmodule
